// ----- rtl/core/quadratic_real_roots_top_defines.svh -----
// assertion macros for the checker file
`ifndef QUADRATIC_REAL_ROOTS_TOP_DEFINES_SVH
`define QUADRATIC_REAL_ROOTS_TOP_DEFINES_SVH

// checked only while out of reset
`define QRR_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    prop) else $error("qrr assertion failed");

// checked on every edge, reset included
`define QRR_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge i_clk) prop) \
    else $error("qrr assertion failed");

`endif

// ----- rtl/core/qrr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_pkg
// Types, constants and helpers for the quadratic real roots pipeline.
// ----------------------------------------------------------------------------
package qrr_pkg;

    localparam int COEF_W     = 16;
    localparam int GUARD_BITS = 15;
    localparam int DISC_W     = 35;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQ_REM_W   = 34;
    localparam int NUM_W      = 34;
    localparam int MAG_W      = 33;
    localparam int SQ_STEPS   = RAD_W / 2;
    localparam int DV_STEPS   = MAG_W;

    localparam logic [1:0] RC_NONE = 2'd0;
    localparam logic [1:0] RC_ONE  = 2'd1;
    localparam logic [1:0] RC_TWO  = 2'd2;

    localparam logic [ROOT_W-1:0] Q16_MAX = 32'h7FFF_FFFF;
    localparam logic [ROOT_W-1:0] Q16_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
    } t_in;

    typedef struct packed {
        logic [1:0]         root_count;
        logic signed [31:0] root1;
        logic signed [31:0] root2;
        logic               degenerate;
        logic               saturated;
    } t_out;

    // travels with the radicand through the square root
    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic               degen;
        logic               dneg;
        logic               dzero;
    } t_sq_meta;

    // travels with the numerators through the divider
    typedef struct packed {
        logic degen;
        logic dneg;
        logic dzero;
        logic neg_p;
        logic neg_m;
    } t_dv_meta;

    typedef struct packed {
        logic              sat;
        logic [ROOT_W-1:0] root;
    } t_clamp;

    function automatic t_clamp clamp_root(input logic neg, input logic [MAG_W-1:0] q);
        t_clamp r;
        logic [MAG_W-1:0] qn;
        qn = ~q + 1'b1;
        r.sat  = 1'b0;
        r.root = q[ROOT_W-1:0];
        if (neg) begin
            if (q > {1'b0, Q16_MIN}) begin
                r.sat  = 1'b1;
                r.root = Q16_MIN;
            end else begin
                r.root = qn[ROOT_W-1:0];
            end
        end else if (q > {1'b0, Q16_MAX}) begin
            r.sat  = 1'b1;
            r.root = Q16_MAX;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/qrr_disc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_disc
// Two-stage discriminant: products, then B*B - 4AC and the scaled radicand.
// ----------------------------------------------------------------------------
module qrr_disc import qrr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_in              i_data,
    output logic             o_vld,
    output logic [RAD_W-1:0] o_x,
    output t_sq_meta         o_meta
);

    logic               r_vld1;
    logic signed [31:0] r_bb;
    logic signed [31:0] r_ac;
    logic signed [15:0] r_a;
    logic signed [15:0] r_b;

    logic               r_vld2;
    logic [RAD_W-1:0]   r_x;
    t_sq_meta           r_meta;

    logic signed [DISC_W-1:0] n_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb <= i_data.coef_b * i_data.coef_b;
            r_ac <= i_data.coef_a * i_data.coef_c;
            r_a  <= i_data.coef_a;
            r_b  <= i_data.coef_b;
        end
    end

    always_comb begin
        n_d = DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x          <= {n_d[MAG_W:0], 30'b0};
            r_meta.coef_a <= r_a;
            r_meta.coef_b <= r_b;
            r_meta.degen  <= (r_a == '0);
            r_meta.dneg   <= n_d[DISC_W-1];
            r_meta.dzero  <= (n_d == '0);
        end
    end

    assign o_vld  = r_vld2;
    assign o_x    = r_x;
    assign o_meta = r_meta;

endmodule

// ----- rtl/core/qrr_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrr_sqrt import qrr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_x,
    input  t_sq_meta          i_meta,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_sq_meta          o_meta
);

    logic                p_vld  [0:SQ_STEPS];
    logic [RAD_W-1:0]    p_x    [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] p_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0]   p_root [0:SQ_STEPS];
    t_sq_meta            p_meta [0:SQ_STEPS];

    assign p_vld[0]  = i_vld;
    assign p_x[0]    = i_x;
    assign p_rem[0]  = '0;
    assign p_root[0] = '0;
    assign p_meta[0] = i_meta;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
        logic                r_vld;
        logic [RAD_W-1:0]    r_x;
        logic [SQ_REM_W-1:0] r_rem;
        logic [ROOT_W-1:0]   r_root;
        t_sq_meta            r_meta;
        logic [SQ_REM_W+1:0] n_sh;
        logic [SQ_REM_W+1:0] n_test;
        logic [SQ_REM_W+1:0] n_diff;
        logic                n_ge;

        always_comb begin
            n_sh   = {p_rem[g], p_x[g][RAD_W-1:RAD_W-2]};
            n_test = {2'b00, p_root[g], 2'b01};
            n_ge   = (n_sh >= n_test);
            n_diff = n_sh - n_test;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= p_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= {p_x[g][RAD_W-3:0], 2'b00};
                r_rem  <= n_ge ? n_diff[SQ_REM_W-1:0] : n_sh[SQ_REM_W-1:0];
                r_root <= {p_root[g][ROOT_W-2:0], n_ge};
                r_meta <= p_meta[g];
            end
        end

        assign p_vld[g+1]  = r_vld;
        assign p_x[g+1]    = r_x;
        assign p_rem[g+1]  = r_rem;
        assign p_root[g+1] = r_root;
        assign p_meta[g+1] = r_meta;
    end

    assign o_vld  = p_vld[SQ_STEPS];
    assign o_root = p_root[SQ_STEPS];
    assign o_meta = p_meta[SQ_STEPS];

endmodule

// ----- rtl/core/qrr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_div
// Forms both numerators, then divides each by A in a two-lane restoring
// divider pipeline, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrr_div import qrr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [ROOT_W-1:0] i_root,
    input  t_sq_meta          i_meta,
    output logic              o_vld,
    output logic [MAG_W-1:0]  o_qp,
    output logic [MAG_W-1:0]  o_qm,
    output t_dv_meta          o_meta
);

    logic signed [NUM_W-1:0] n_base;
    logic signed [NUM_W-1:0] n_np;
    logic signed [NUM_W-1:0] n_nm;
    logic        [NUM_W-1:0] n_absp;
    logic        [NUM_W-1:0] n_absm;
    logic        [15:0]      n_absa;

    always_comb begin
        n_base = -(NUM_W'(i_meta.coef_b) <<< GUARD_BITS);
        n_np   = n_base + $signed({2'b00, i_root});
        n_nm   = n_base - $signed({2'b00, i_root});
        n_absp = n_np[NUM_W-1] ? -n_np : n_np;
        n_absm = n_nm[NUM_W-1] ? -n_nm : n_nm;
        n_absa = i_meta.coef_a[15] ? -i_meta.coef_a : i_meta.coef_a;
    end

    logic             p_vld [0:DV_STEPS];
    logic [MAG_W-1:0] p_np  [0:DV_STEPS];
    logic [MAG_W-1:0] p_nm  [0:DV_STEPS];
    logic [15:0]      p_rp  [0:DV_STEPS];
    logic [15:0]      p_rm  [0:DV_STEPS];
    logic [MAG_W-1:0] p_qp  [0:DV_STEPS];
    logic [MAG_W-1:0] p_qm  [0:DV_STEPS];
    logic [15:0]      p_d   [0:DV_STEPS];
    t_dv_meta         p_meta[0:DV_STEPS];

    // entry stage: magnitudes and quotient signs
    logic             r_e_vld;
    logic [MAG_W-1:0] r_e_np;
    logic [MAG_W-1:0] r_e_nm;
    logic [15:0]      r_e_d;
    t_dv_meta         r_e_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_np         <= n_absp[MAG_W-1:0];
            r_e_nm         <= n_absm[MAG_W-1:0];
            r_e_d          <= n_absa;
            r_e_meta.degen <= i_meta.degen;
            r_e_meta.dneg  <= i_meta.dneg;
            r_e_meta.dzero <= i_meta.dzero;
            r_e_meta.neg_p <= n_np[NUM_W-1] ^ i_meta.coef_a[15];
            r_e_meta.neg_m <= n_nm[NUM_W-1] ^ i_meta.coef_a[15];
        end
    end

    assign p_vld[0]  = r_e_vld;
    assign p_np[0]   = r_e_np;
    assign p_nm[0]   = r_e_nm;
    assign p_rp[0]   = '0;
    assign p_rm[0]   = '0;
    assign p_qp[0]   = '0;
    assign p_qm[0]   = '0;
    assign p_d[0]    = r_e_d;
    assign p_meta[0] = r_e_meta;

    for (genvar g = 0; g < DV_STEPS; g++) begin : g_step
        logic             r_vld;
        logic [MAG_W-1:0] r_np;
        logic [MAG_W-1:0] r_nm;
        logic [15:0]      r_rp;
        logic [15:0]      r_rm;
        logic [MAG_W-1:0] r_qp;
        logic [MAG_W-1:0] r_qm;
        logic [15:0]      r_d;
        t_dv_meta         r_meta;
        logic [16:0]      n_shp;
        logic [16:0]      n_shm;
        logic [16:0]      n_difp;
        logic [16:0]      n_difm;
        logic             n_gep;
        logic             n_gem;

        always_comb begin
            n_shp  = {p_rp[g], p_np[g][MAG_W-1]};
            n_shm  = {p_rm[g], p_nm[g][MAG_W-1]};
            n_gep  = (n_shp >= {1'b0, p_d[g]});
            n_gem  = (n_shm >= {1'b0, p_d[g]});
            n_difp = n_shp - {1'b0, p_d[g]};
            n_difm = n_shm - {1'b0, p_d[g]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= p_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_np   <= {p_np[g][MAG_W-2:0], 1'b0};
                r_nm   <= {p_nm[g][MAG_W-2:0], 1'b0};
                r_rp   <= n_gep ? n_difp[15:0] : n_shp[15:0];
                r_rm   <= n_gem ? n_difm[15:0] : n_shm[15:0];
                r_qp   <= {p_qp[g][MAG_W-2:0], n_gep};
                r_qm   <= {p_qm[g][MAG_W-2:0], n_gem};
                r_d    <= p_d[g];
                r_meta <= p_meta[g];
            end
        end

        assign p_vld[g+1]  = r_vld;
        assign p_np[g+1]   = r_np;
        assign p_nm[g+1]   = r_nm;
        assign p_rp[g+1]   = r_rp;
        assign p_rm[g+1]   = r_rm;
        assign p_qp[g+1]   = r_qp;
        assign p_qm[g+1]   = r_qm;
        assign p_d[g+1]    = r_d;
        assign p_meta[g+1] = r_meta;
    end

    assign o_vld  = p_vld[DV_STEPS];
    assign o_qp   = p_qp[DV_STEPS];
    assign o_qm   = p_qm[DV_STEPS];
    assign o_meta = p_meta[DV_STEPS];

endmodule

// ----- rtl/core/quadratic_real_roots_top.sv -----
`timescale 1ns / 1ps
// pipeline: 2 discriminant stages, the 32-stage square root, the 34-stage divider
// and 1 output register lie between request accept and o_out_valid
// throughput: one request per cycle; a two-entry output buffer keeps taking
// requests while a result waits, and stalls the pipeline only when full
// reset: synchronous active low, clears all valid bits; data paths are not reset
// ----------------------------------------------------------------------------
// quadratic_real_roots_top
// Real roots of A*x^2 + B*x + C = 0 from Q8.8 coefficients, Q16.16 roots.
// ----------------------------------------------------------------------------
module quadratic_real_roots_top import qrr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic             w_en;
    logic             w_d_vld;
    logic [RAD_W-1:0] w_d_x;
    t_sq_meta         w_d_meta;
    logic              w_s_vld;
    logic [ROOT_W-1:0] w_s_root;
    t_sq_meta          w_s_meta;
    logic             w_v_vld;
    logic [MAG_W-1:0] w_v_qp;
    logic [MAG_W-1:0] w_v_qm;
    t_dv_meta         w_v_meta;

    logic r_out_vld;
    t_out r_out;
    logic r_skd_vld;
    t_out r_skd;

    t_clamp n_cp;
    t_clamp n_cm;
    t_out   n_res;
    logic   n_push;
    logic   n_pop;

    assign w_en       = !r_skd_vld;
    assign o_in_ready = w_en;

    qrr_disc u_disc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (i_in_valid),
        .i_data (i_in_data),
        .o_vld  (w_d_vld),
        .o_x    (w_d_x),
        .o_meta (w_d_meta)
    );

    qrr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_d_vld),
        .i_x    (w_d_x),
        .i_meta (w_d_meta),
        .o_vld  (w_s_vld),
        .o_root (w_s_root),
        .o_meta (w_s_meta)
    );

    qrr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_s_vld),
        .i_root (w_s_root),
        .i_meta (w_s_meta),
        .o_vld  (w_v_vld),
        .o_qp   (w_v_qp),
        .o_qm   (w_v_qm),
        .o_meta (w_v_meta)
    );

    always_comb begin
        n_cp  = clamp_root(w_v_meta.neg_p, w_v_qp);
        n_cm  = clamp_root(w_v_meta.neg_m, w_v_qm);
        n_res = '0;
        n_res.degenerate = w_v_meta.degen;
        if (!w_v_meta.degen && !w_v_meta.dneg) begin
            n_res.root1 = n_cp.root;
            if (w_v_meta.dzero) begin
                n_res.root_count = RC_ONE;
                n_res.root2      = n_cp.root;
                n_res.saturated  = n_cp.sat;
            end else begin
                n_res.root_count = RC_TWO;
                n_res.root2      = n_cm.root;
                n_res.saturated  = n_cp.sat | n_cm.sat;
            end
        end else begin
            n_res.root_count = RC_NONE;
        end
    end

    assign n_push = w_en && w_v_vld;
    assign n_pop  = r_out_vld && i_out_ready;

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (n_pop) begin
                r_skd_vld <= 1'b0;
            end
        end else if (n_push) begin
            if (r_out_vld && !n_pop) begin
                r_skd_vld <= 1'b1;
            end
            r_out_vld <= 1'b1;
        end else if (n_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (n_pop) begin
                r_out <= r_skd;
            end
        end else if (n_push) begin
            if (r_out_vld && !n_pop) begin
                r_skd <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/qrr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_checker
// Port-level checks on the result channel of the roots block.
// ----------------------------------------------------------------------------
`include "quadratic_real_roots_top_defines.svh"

module qrr_checker import qrr_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a stalled result keeps its payload
    `QRR_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // nothing comes out right after reset
    `QRR_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_out_valid)

    // degenerate or no-root results carry zero roots and no saturation
    `QRR_ASSERT(a_none_zero, o_out_valid && o_out_data.root_count == RC_NONE |-> o_out_data.root1 == 0 && o_out_data.root2 == 0 && !o_out_data.saturated)

    // a degenerate result never reports roots
    `QRR_ASSERT(a_degen, o_out_valid && o_out_data.degenerate |-> o_out_data.root_count == RC_NONE)

    // a single root repeats in both fields
    `QRR_ASSERT(a_single, o_out_valid && o_out_data.root_count == RC_ONE |-> o_out_data.root1 == o_out_data.root2)

endmodule

bind quadratic_real_roots_top qrr_checker u_qrr_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives coefficient sets into the quadratic root pipeline with random gaps and
// output stalls, predicts each result in 64-bit integer arithmetic and
// compares every returned result with its prediction, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import qrr_pkg::*;

    localparam int LATENCY   = 69;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 1880;
    localparam int CALM_TAIL = 300;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    t_in  pending_reqs[$];
    t_out expected_roots[$];
    int   n_mismatch;
    int   n_sent;
    int   n_total;
    int   cyc;
    int   in_gap;
    int   out_gap;
    // ready seen at the last rising edge, for the handshake decision
    logic o_in_ready_q;

    quadratic_real_roots_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // bitwise integer square root, floor
    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned rem, res, bt;
        rem = x;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > rem) bt >>= 2;
        while (bt != 0) begin
            if (rem >= res + bt) begin
                rem -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_out solve_quadratic(input t_in q);
        t_out   r;
        longint a, b, c, disc, base;
        longint unsigned s;
        logic   sat;
        a = q.coef_a;
        b = q.coef_b;
        c = q.coef_c;
        sat = 1'b0;
        r = '0;
        r.root_count = RC_NONE;
        if (a == 0) begin
            r.degenerate = 1'b1;
        end else begin
            disc = b * b - 4 * a * c;
            if (disc >= 0) begin
                s = isqrt(longint'(disc) << 30);
                base = -b * (64'sd1 <<< 15);
                // longint division truncates toward zero
                r.root1 = clamp32((base + longint'(s)) / a, sat);
                if (disc > 0) begin
                    r.root2 = clamp32((base - longint'(s)) / a, sat);
                    r.root_count = RC_TWO;
                end else begin
                    r.root2 = r.root1;
                    r.root_count = RC_ONE;
                end
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    function automatic t_in make_req(input int a, input int b, input int c);
        t_in q;
        q.coef_a = a[15:0];
        q.coef_b = b[15:0];
        q.coef_c = c[15:0];
        return q;
    endfunction

    // mostly small magnitudes so roots land in range, some full-range noise
    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    initial begin
        t_in q;
        int  k;
        int  m;
        i_rst_n = 1'b0;
        n_sent = 0;
        // extremes, degenerate, negative, zero and positive discriminants, saturation
        pending_reqs.push_back(make_req(0, 5, 7));
        pending_reqs.push_back(make_req(0, 0, 0));
        pending_reqs.push_back(make_req(256, 0, 256));
        pending_reqs.push_back(make_req(256, -512, 256));
        pending_reqs.push_back(make_req(256, 512, 256));
        pending_reqs.push_back(make_req(256, 0, -256));
        pending_reqs.push_back(make_req(-256, 256, 512));
        pending_reqs.push_back(make_req(1, 32767, 0));
        pending_reqs.push_back(make_req(1, -32768, 0));
        pending_reqs.push_back(make_req(-1, -32768, 32767));
        pending_reqs.push_back(make_req(32767, 32767, 32767));
        pending_reqs.push_back(make_req(-32768, -32768, -32768));
        pending_reqs.push_back(make_req(-32768, 32767, 32767));
        pending_reqs.push_back(make_req(32767, -32768, -32768));
        pending_reqs.push_back(make_req(1, 0, -32768));
        pending_reqs.push_back(make_req(-1, 0, 32767));
        pending_reqs.push_back(make_req(1, 2, 1));
        pending_reqs.push_back(make_req(-32768, 0, 0));
        pending_reqs.push_back(make_req(4, -4, 1));
        pending_reqs.push_back(make_req(0, -32768, 32767));
        for (k = 0; k < N_RANDOM; k++) begin
            q.coef_a = rand_coef();
            q.coef_b = rand_coef();
            q.coef_c = rand_coef();
            if ($urandom_range(0, 9) == 0) begin
                // force a double root: b = 2*m*a, c = m*m*a
                m = $urandom_range(1, 3);
                q.coef_a = 16'($urandom_range(1, 100));
                q.coef_c = 16'(int'(q.coef_a) * m * m);
                q.coef_b = 16'(2 * m * int'(q.coef_a));
            end else if ($urandom_range(0, 19) == 0) begin
                q.coef_a = 16'h0000;
            end
            pending_reqs.push_back(q);
        end
        n_total = pending_reqs.size();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            in_gap     <= 0;
        end else if (!(i_in_valid && !o_in_ready_q)) begin
            // previous request was taken (or none pending)
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_reqs.pop_front();
                if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 15) == 0)
                    in_gap <= $urandom_range(1, 17);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        o_in_ready_q <= o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_roots.push_back(solve_quadratic(i_in_data));
            n_sent <= n_sent + 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= 0;
        end else if (out_gap > 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (n_sent < n_total - CALM_TAIL && $urandom_range(0, 15) == 0) begin
            out_gap     <= $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            n_mismatch <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if (expected_roots.size() == 0) begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10)
                    $display("unexpected result %p", o_out_data);
            end else begin
                want = expected_roots.pop_front();
                if (o_out_data !== want) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("mismatch: expected %p, got %p", want, o_out_data);
                end
            end
        end
    end

    initial begin
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        o_in_ready_q = 1'b0;
        cyc = 0;
        wait (i_rst_n);
        while ((pending_reqs.size() > 0 || i_in_valid || expected_roots.size() > 0)
               && cyc < MAX_CYC) begin
            @(posedge i_clk);
            cyc++;
        end
        if (cyc >= MAX_CYC) begin
            $display("FAIL quadratic_real_roots_top");
        end else begin
            repeat (2 * LATENCY) @(posedge i_clk);
            #1;
            if (n_mismatch == 0 && expected_roots.size() == 0)
                $display("PASS quadratic_real_roots_top");
            else
                $display("FAIL quadratic_real_roots_top");
        end
        $finish;
    end
endmodule
